/* rtl/gnmc_pkg.sv */
// Package for the grid neighbour mine counter: field widths, size limits,
// controller states and the command/status structs between the controller and datapath.
// No dependencies.
package gnmc_pkg;

  localparam int unsigned MAX_COLS = 32;
  localparam int unsigned MAX_ROWS = 4095;

  localparam int unsigned RowW   = 12;
  localparam int unsigned ColW   = 6;
  localparam int unsigned CountW = 4;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned CfgIdxW = 1;

  // Line buffer tap index and the counter that holds up to MAX_COLS + 1.
  localparam int unsigned LbIdxW = $clog2(MAX_COLS);
  localparam int unsigned PcW    = $clog2(MAX_COLS + 2);

  localparam logic [CfgIdxW-1:0] CFG_NUM_ROWS = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_NUM_COLS = CfgIdxW'(1);

  typedef enum logic {
    GNMC_RUN,
    GNMC_FLUSH
  } gnmc_state_e;

  typedef struct packed {
    logic shift;
    logic phantom;
    logic clear;
  } gnmc_cmd_t;

  typedef struct packed {
    logic can_shift;
    logic last_in;
    logic flush_done;
  } gnmc_stat_t;

endpackage

/* rtl/gnmc_ctrl.sv */
// Controller for the grid neighbour mine counter: accepts cells while running
// and drives the end-of-field flush. Depends on gnmc_pkg.
module gnmc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cfg_we_i,
  input  gnmc_pkg::gnmc_stat_t  stat_i,
  output gnmc_pkg::gnmc_cmd_t   cmd_o
);
  import gnmc_pkg::*;

  gnmc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GNMC_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    priority if (cfg_we_i) begin
      state_d = GNMC_RUN;
    end else begin
      unique case (state_q)
        GNMC_RUN: begin
          if (cmd_o.shift && stat_i.last_in) begin
            state_d = GNMC_FLUSH;
          end
        end
        GNMC_FLUSH: begin
          if (cmd_o.shift && stat_i.flush_done) begin
            state_d = GNMC_RUN;
          end
        end
        default: state_d = GNMC_RUN;
      endcase
    end
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.shift   = 1'b0;
    cmd_o.phantom = 1'b0;
    cmd_o.clear   = cfg_we_i;
    unique case (state_q)
      GNMC_RUN: begin
        in_ready_o  = stat_i.can_shift && !cfg_we_i;
        cmd_o.shift = in_valid_i && stat_i.can_shift && !cfg_we_i;
      end
      GNMC_FLUSH: begin
        cmd_o.shift   = stat_i.can_shift && !cfg_we_i;
        cmd_o.phantom = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_flush_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == GNMC_FLUSH && cmd_o.shift && stat_i.flush_done) |=> state_q == GNMC_RUN)
    else $error("flush did not end after its final shift");

  a_flush_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == GNMC_RUN && cmd_o.shift && stat_i.last_in && !cfg_we_i)
      |=> state_q == GNMC_FLUSH)
    else $error("last cell of the field did not start the flush");

  a_no_input_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == GNMC_FLUSH) |-> !in_ready_o)
    else $error("input ready raised during the flush");

endmodule

/* rtl/gnmc_dp.sv */
// Datapath for the grid neighbour mine counter: two row delay lines, the 3x3
// window, position counters and the result register. Depends on gnmc_pkg.
module gnmc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gnmc_pkg::gnmc_cmd_t           cmd_i,
  output gnmc_pkg::gnmc_stat_t          stat_o,
  input  logic [gnmc_pkg::RowW-1:0]     rows_i,
  input  logic [gnmc_pkg::ColW-1:0]     cols_i,
  input  logic                          is_mine_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gnmc_pkg::RowW-1:0]     out_row_o,
  output logic [gnmc_pkg::ColW-1:0]     out_col_o,
  output logic                          cell_is_mine_o,
  output logic [gnmc_pkg::CountW-1:0]   mine_count_o,
  output logic                          field_last_o
);
  import gnmc_pkg::*;

  logic [MAX_COLS-1:0] lb1_q, lb2_q;
  logic [2:0]          win_top_q, win_mid_q, win_bot_q;
  logic [LbIdxW-1:0]   lb_idx;
  logic                lb1_tap, lb2_tap, shift_bit;

  logic [RowW-1:0]     in_row_q, emit_row_q;
  logic [ColW-1:0]     in_col_q, emit_col_q;
  logic [PcW-1:0]      prime_q, flush_q;
  logic                win_valid_q, out_valid_q;

  logic [RowW-1:0]     out_row_q;
  logic [ColW-1:0]     out_col_q;
  logic                out_mine_q, out_last_q;
  logic [CountW-1:0]   out_count_q;

  logic [RowW-1:0]     row_max;
  logic [ColW-1:0]     col_max;
  logic                last_in, flush_done, prime_full, field_end;
  logic                out_load, can_shift, emit_last;
  logic                top_ok, bot_ok, left_ok, right_ok;
  logic [7:0]          nb;
  logic [CountW-1:0]   nb_sum;

  assign row_max    = rows_i - RowW'(1);
  assign col_max    = cols_i - ColW'(1);
  assign lb_idx     = col_max[LbIdxW-1:0];
  assign lb1_tap    = lb1_q[lb_idx];
  assign lb2_tap    = lb2_q[lb_idx];
  assign shift_bit  = cmd_i.phantom ? 1'b0 : is_mine_i;

  assign last_in    = (in_row_q == row_max) && (in_col_q == col_max);
  assign flush_done = (flush_q == PcW'(cols_i));
  assign prime_full = (prime_q == PcW'(cols_i) + PcW'(1));
  assign field_end  = cmd_i.shift && cmd_i.phantom && flush_done;
  assign out_load   = win_valid_q && (!out_valid_q || out_ready_i);
  assign can_shift  = !win_valid_q || out_load;
  assign emit_last  = (emit_row_q == row_max) && (emit_col_q == col_max);

  assign stat_o.can_shift  = can_shift;
  assign stat_o.last_in    = last_in;
  assign stat_o.flush_done = flush_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      lb1_q     <= {lb1_q[MAX_COLS-2:0], shift_bit};
      lb2_q     <= {lb2_q[MAX_COLS-2:0], lb1_tap};
      win_bot_q <= {win_bot_q[1:0], shift_bit};
      win_mid_q <= {win_mid_q[1:0], lb1_tap};
      win_top_q <= {win_top_q[1:0], lb2_tap};
    end
  end

  assign top_ok   = (emit_row_q != '0);
  assign bot_ok   = (emit_row_q != row_max);
  assign left_ok  = (emit_col_q != '0);
  assign right_ok = (emit_col_q != col_max);

  assign nb = {win_top_q[2] & top_ok & left_ok,
               win_top_q[1] & top_ok,
               win_top_q[0] & top_ok & right_ok,
               win_mid_q[2] & left_ok,
               win_mid_q[0] & right_ok,
               win_bot_q[2] & bot_ok & left_ok,
               win_bot_q[1] & bot_ok,
               win_bot_q[0] & bot_ok & right_ok};

  always_comb begin
    nb_sum = '0;
    for (int i = 0; i < 8; i++) begin
      nb_sum = nb_sum + CountW'(nb[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      prime_q     <= '0;
      flush_q     <= '0;
      emit_row_q  <= '0;
      emit_col_q  <= '0;
      win_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.clear) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      prime_q     <= '0;
      flush_q     <= '0;
      emit_row_q  <= '0;
      emit_col_q  <= '0;
      win_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.shift && !cmd_i.phantom) begin
        if (last_in) begin
          in_row_q <= '0;
          in_col_q <= '0;
        end else if (in_col_q == col_max) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RowW'(1);
        end else begin
          in_col_q <= in_col_q + ColW'(1);
        end
      end

      if (field_end) begin
        prime_q <= '0;
        flush_q <= '0;
      end else if (cmd_i.shift) begin
        if (!prime_full) begin
          prime_q <= prime_q + PcW'(1);
        end
        if (cmd_i.phantom) begin
          flush_q <= flush_q + PcW'(1);
        end
      end

      if (out_load) begin
        if (emit_last) begin
          emit_row_q <= '0;
          emit_col_q <= '0;
        end else if (emit_col_q == col_max) begin
          emit_col_q <= '0;
          emit_row_q <= emit_row_q + RowW'(1);
        end else begin
          emit_col_q <= emit_col_q + ColW'(1);
        end
      end

      if (cmd_i.shift) begin
        win_valid_q <= prime_full;
      end else if (out_load) begin
        win_valid_q <= 1'b0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q   <= emit_row_q;
      out_col_q   <= emit_col_q;
      out_mine_q  <= win_mid_q[1];
      out_count_q <= win_mid_q[1] ? '0 : nb_sum;
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign cell_is_mine_o = out_mine_q;
  assign mine_count_o   = out_count_q;
  assign field_last_o   = out_last_q;

  a_emit_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_col_q < cols_i)
    else $error("emit column outside the field");

  a_last_is_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_row_q == row_max) && (out_col_q == col_max))
    else $error("final result is not the field's last cell");

  a_mine_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_mine_q) |-> (out_count_q == '0))
    else $error("mine cell reported with a nonzero count");

endmodule

/* rtl/grid_neighbour_mine_count_top.sv */
// Grid neighbour mine counter, top level: size registers, controller and datapath.
// Throughput is one cell per cycle unless the output stalls or a flush runs; the result
// for cell p is registered at the output once cell p+C+1 is in and that register is free
// (C = effective column count). Input ready is low during a flush of C+1 phantom cells.
// Reset sets both size registers to 1 and leaves the field empty; any register write
// abandons the field in progress. Depends on gnmc_pkg, gnmc_ctrl and gnmc_dp.
module grid_neighbour_mine_count_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gnmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gnmc_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          is_mine_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gnmc_pkg::RowW-1:0]     out_row_o,
  output logic [gnmc_pkg::ColW-1:0]     out_col_o,
  output logic                          cell_is_mine_o,
  output logic [gnmc_pkg::CountW-1:0]   mine_count_o,
  output logic                          field_last_o
);
  import gnmc_pkg::*;

  logic [RowW-1:0] rows_q, rows_d, row_val;
  logic [ColW-1:0] cols_q, cols_d, col_val;
  gnmc_cmd_t       cmd;
  gnmc_stat_t      stat;

  assign row_val = cfg_data_i[RowW-1:0];
  assign col_val = cfg_data_i[ColW-1:0];

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_ROWS: begin
          priority if (row_val == '0) begin
            rows_d = RowW'(1);
          end else if (row_val > RowW'(MAX_ROWS)) begin
            rows_d = RowW'(MAX_ROWS);
          end else begin
            rows_d = row_val;
          end
        end
        CFG_NUM_COLS: begin
          priority if (col_val == '0) begin
            cols_d = ColW'(1);
          end else if (col_val > ColW'(MAX_COLS)) begin
            cols_d = ColW'(MAX_COLS);
          end else begin
            cols_d = col_val;
          end
        end
        default: begin
          rows_d = rows_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RowW'(1);
      cols_q <= ColW'(1);
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  gnmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cfg_we_i   (cfg_we_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gnmc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .rows_i         (rows_q),
    .cols_i         (cols_q),
    .is_mine_i      (is_mine_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .cell_is_mine_o (cell_is_mine_o),
    .mine_count_o   (mine_count_o),
    .field_last_o   (field_last_o)
  );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for grid_neighbour_mine_count_top. A scoreboard class keeps its own
// copy of the field and the size registers and predicts every cell report from the transfers.
// Depends on gnmc_pkg and the RTL top level; plain tasks drive cells and size register writes.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gnmc_pkg::*;

  typedef struct {
    logic [RowW-1:0]   row_idx;
    logic [ColW-1:0]   col_idx;
    logic              mine;
    logic [CountW-1:0] count;
    logic              is_last;
  } cell_report_t;

  class mine_count_board;
    logic [RowW-1:0] rows_reg;
    logic [ColW-1:0] cols_reg;
    bit              field_q[$];
    cell_report_t    report_q[$];
    int unsigned     errors;

    function new();
      rows_reg = RowW'(1);
      cols_reg = ColW'(1);
      errors = 0;
    endfunction

    function int eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return int'(rows_reg);
    endfunction

    function int eff_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return int'(cols_reg);
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    // Any size write abandons the field in progress.
    function void configure(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      if (idx == CFG_NUM_ROWS) rows_reg = data[RowW-1:0];
      else if (idx == CFG_NUM_COLS) cols_reg = data[ColW-1:0];
      field_q.delete();
    endfunction

    function void add_report(int pos, bit is_last);
      int nrows, ncols, r, c;
      cell_report_t rep;
      nrows = eff_rows();
      ncols = eff_cols();
      r = pos / ncols;
      c = pos % ncols;
      rep.row_idx = r[RowW-1:0];
      rep.col_idx = c[ColW-1:0];
      rep.mine = field_q[pos];
      rep.count = '0;
      rep.is_last = is_last;
      if (!rep.mine) begin
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            int nr, nc;
            nr = r + dr;
            nc = c + dc;
            if ((dr != 0 || dc != 0) && nr >= 0 && nr < nrows && nc >= 0 && nc < ncols &&
                nr * ncols + nc < field_q.size())
              rep.count = rep.count + CountW'(field_q[nr * ncols + nc]);
          end
        end
      end
      report_q = {report_q, rep};
    endfunction

    // A cell is reported once the cell one row and one column past it has arrived; the last
    // cell of the field releases everything still held back.
    function void note_cell(bit m);
      int nrows, ncols, pos;
      nrows = eff_rows();
      ncols = eff_cols();
      pos = field_q.size();
      field_q = {field_q, m};
      if (pos >= ncols + 1) add_report(pos - ncols - 1, 1'b0);
      if (pos == nrows * ncols - 1) begin
        for (int e = (pos >= ncols + 1) ? pos - ncols : 0; e <= pos; e++)
          add_report(e, e == pos);
        field_q.delete();
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(cell_report_t got);
      cell_report_t want;
      if (report_q.size() == 0) begin
        $error("report for row %0d col %0d with none expected", got.row_idx, got.col_idx);
        errors++;
        return;
      end
      want = report_q.pop_front();
      compare("out_row", 32'(want.row_idx), 32'(got.row_idx));
      compare("out_col", 32'(want.col_idx), 32'(got.col_idx));
      compare("cell_is_mine", 32'(want.mine), 32'(got.mine));
      compare("mine_count", 32'(want.count), 32'(got.count));
      compare("field_last", 32'(want.is_last), 32'(got.is_last));
    endfunction
  endclass

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = MAX_COLS + 8;
  localparam int unsigned RandomCells = 100;
  localparam bit [8:0]    RingField   = 9'b111_101_111;
  localparam bit [3:0]    RowField    = 4'b0100;
  localparam bit [5:0]    CutField    = 6'b100110;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_NUM_ROWS;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               is_mine_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [RowW-1:0]    out_row_o;
  logic [ColW-1:0]    out_col_o;
  logic               cell_is_mine_o;
  logic [CountW-1:0]  mine_count_o;
  logic               field_last_o;

  mine_count_board board = new();
  cell_report_t    seen;
  bit              steady = 1'b0;
  int unsigned     cycle_count = 0;
  int unsigned     random_cells = 0;

  grid_neighbour_mine_count_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .is_mine_i      (is_mine_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .cell_is_mine_o (cell_is_mine_o),
    .mine_count_o   (mine_count_o),
    .field_last_o   (field_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 31);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.row_idx = out_row_o;
      seen.col_idx = out_col_o;
      seen.mine = cell_is_mine_o;
      seen.count = mine_count_o;
      seen.is_last = field_last_o;
      board.check_result(seen);
    end
    if (cycle_count == CycleLimit) begin
      $display("** grid_neighbour_mine_count_top: FAILED **");
      $finish;
    end
  end

  task automatic send_cell(bit m);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    is_mine_i <= m;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_cell(m);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (board.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_size(logic [CfgW-1:0] rows_data, logic [CfgW-1:0] cols_data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_NUM_ROWS;
    cfg_data_i <= rows_data;
    @(negedge clk_i);
    board.configure(CFG_NUM_ROWS, rows_data);
    cfg_idx_i <= CFG_NUM_COLS;
    cfg_data_i <= cols_data;
    @(negedge clk_i);
    board.configure(CFG_NUM_COLS, cols_data);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_cells(int unsigned n, int unsigned density);
    repeat (n) begin
      if (random_cells >= RandomCells) break;
      send_cell($urandom_range(99) < density);
      random_cells++;
      if ($urandom_range(39) == 0) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (board.pending() != 0) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    int unsigned kind, rows_d, cols_d, density, ncells;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_cell(1'b1);
    send_cell(1'b0);
    set_size(12'd3, 12'd3);
    for (int i = 8; i >= 0; i--) send_cell(RingField[i]);
    set_size(12'd0, 12'd0);
    send_cell(1'b1);
    set_size(12'd1, 12'hFC4);
    for (int i = 3; i >= 0; i--) send_cell(RowField[i]);
    set_size(12'd4095, 12'd2);
    for (int i = 5; i >= 0; i--) send_cell(CutField[i]);

    while (random_cells < RandomCells) begin
      steady = (random_cells >= 30) && (random_cells < 70);
      kind = $urandom_range(9);
      if ($urandom_range(3) == 0) density = $urandom_range(1) ? 100 : 0;
      else density = $urandom_range(100);
      if (kind == 0) begin
        rows_d = $urandom_range(1, 2);
        cols_d = $urandom_range(32, 63);
      end else if (kind == 1) begin
        rows_d = $urandom_range(6, 4095);
        cols_d = $urandom_range(0, 8);
      end else begin
        rows_d = $urandom_range(0, 5);
        cols_d = $urandom_range(0, 8);
      end
      if ($urandom_range(3) == 0) cols_d += $urandom_range(63) << ColW;
      set_size(CfgW'(rows_d), CfgW'(cols_d));
      ncells = board.eff_rows() * board.eff_cols();
      if (kind == 1) send_cells($urandom_range(1, 3 * board.eff_cols()), density);
      else repeat ($urandom_range(1, 2)) send_cells(ncells, density);
    end

    steady = 1'b0;
    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("** grid_neighbour_mine_count_top: PASSED **");
    end else begin
      $display("** grid_neighbour_mine_count_top: FAILED **");
    end
    $finish;
  end
endmodule
